/* design/b64sc_pkg.sv */
package b64sc_pkg;

  // Direction codes held in the mode register
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // Padding character '='
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Most results one group can give
  localparam int unsigned RES_MAX = 4;

  // One finished group, passed from the front to the back.
  // sym[0] goes out first; keep marks the results that are given.
  typedef struct packed {
    logic [RES_MAX-1:0][7:0] sym;
    logic [RES_MAX-1:0]      keep;
    logic                    bad;
  } group_t;

  // Character classification result
  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  // Alphabet: sextet to character
  function automatic logic [7:0] alpha_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  // Reverse alphabet: character to sextet, ok low when outside the alphabet
  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t s;
    s.ok  = 1'b1;
    s.val = '0;
    if (c inside {[8'h41:8'h5A]}) begin
      s.val = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      s.val = 6'(c - 8'h61 + 8'd26);
    end else if (c inside {[8'h30:8'h39]}) begin
      s.val = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      s.val = 6'd62;
    end else if (c == 8'h2F) begin
      s.val = 6'd63;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

/* design/b64sc_queue.sv */
module b64sc_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  b64sc_pkg::group_t push_data,
  output logic              full,
  input  logic              pop,
  output b64sc_pkg::group_t pop_data,
  output logic              empty
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

  b64sc_pkg::group_t mem [DEPTH];
  logic [IW-1:0] wr_ptr;
  logic [IW-1:0] rd_ptr;
  logic [CW-1:0] count;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  assign pop_data = mem[rd_ptr];
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);

endmodule

/* design/b64sc_front.sv */
module b64sc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              direction_mode,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_symbol,
  input  logic              last_in,
  output logic              q_push,
  output b64sc_pkg::group_t q_data,
  input  logic              q_full
);

  logic        mode;
  logic [23:0] group_bits;
  logic [1:0]  group_count;
  logic [3:0]  pad_marks;
  logic        bad_seen;

  logic        accept;
  logic [2:0]  n_items;

  logic [23:0] enc_bits;
  logic        enc_done;
  b64sc_pkg::group_t enc_grp;

  b64sc_pkg::sextet_t sx;
  logic        is_pad;
  logic [5:0]  dec_v;
  logic [23:0] dec_bits;
  logic [3:0]  dec_pad;
  logic [3:0]  pad_full;
  logic        dec_bad;
  logic        dec_done;
  logic [2:0][7:0] dec_bytes;
  b64sc_pkg::group_t dec_grp;

  logic        done;
  logic [23:0] group_bits_next;
  logic [3:0]  pad_marks_next;
  logic        bad_seen_next;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign n_items  = {1'b0, group_count} + 3'd1;

  // Encode: place the byte and map the group to four characters
  always_comb begin
    enc_bits = group_bits;
    case (group_count)
      2'd0:    enc_bits[23:16] = in_symbol;
      2'd1:    enc_bits[15:8]  = group_bits[15:8] | in_symbol;
      default: enc_bits[7:0]   = group_bits[7:0] | in_symbol;
    endcase
    enc_done       = (n_items >= 3'd3) || last_in;
    enc_grp.sym[0] = b64sc_pkg::alpha_char(enc_bits[23:18]);
    enc_grp.sym[1] = b64sc_pkg::alpha_char(enc_bits[17:12]);
    enc_grp.sym[2] = (n_items >= 3'd2) ? b64sc_pkg::alpha_char(enc_bits[11:6])
                                       : b64sc_pkg::PAD_CHAR;
    enc_grp.sym[3] = (n_items >= 3'd3) ? b64sc_pkg::alpha_char(enc_bits[5:0])
                                       : b64sc_pkg::PAD_CHAR;
    enc_grp.keep   = 4'b1111;
    enc_grp.bad    = 1'b0;
  end

  // Decode: classify the character, place the sextet, work out surviving bytes
  always_comb begin
    sx       = b64sc_pkg::sextet_of(in_symbol);
    is_pad   = (in_symbol == b64sc_pkg::PAD_CHAR);
    dec_v    = (is_pad || !sx.ok) ? 6'd0 : sx.val;
    dec_bad  = bad_seen || (!is_pad && !sx.ok);
    dec_pad  = pad_marks | ({3'b000, is_pad} << group_count);
    dec_bits = group_bits;
    case (group_count)
      2'd0:    dec_bits[23:18] = dec_v;
      2'd1:    dec_bits[17:12] = dec_v;
      2'd2:    dec_bits[11:6]  = dec_v;
      default: dec_bits[5:0]   = dec_v;
    endcase
    dec_done = (group_count == 2'd3) || last_in;
    // a short final group counts as padded
    for (int k = 0; k < 4; k++) begin
      pad_full[k] = dec_pad[k] || (3'(k) >= n_items);
    end
    dec_bytes[0] = dec_bits[23:16];
    dec_bytes[1] = dec_bits[15:8];
    dec_bytes[2] = dec_bits[7:0];
    for (int k = 0; k < 3; k++) begin
      dec_grp.sym[k]  = dec_bytes[k];
      dec_grp.keep[k] = (dec_bytes[k] != 8'd0) || !(pad_full[k] || pad_full[k+1]);
    end
    dec_grp.sym[3]  = 8'd0;
    dec_grp.keep[3] = 1'b0;
    dec_grp.bad     = dec_bad;
  end

  // Mode select
  always_comb begin
    if (mode == b64sc_pkg::MODE_DECODE) begin
      done            = dec_done;
      q_data          = dec_grp;
      group_bits_next = dec_bits;
      pad_marks_next  = dec_pad;
      bad_seen_next   = dec_bad;
    end else begin
      done            = enc_done;
      q_data          = enc_grp;
      group_bits_next = enc_bits;
      pad_marks_next  = pad_marks;
      bad_seen_next   = bad_seen;
    end
  end

  // A group with no surviving result is dropped here
  assign q_push = accept && done && (|q_data.keep) && !cfg_write;

  // Group state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= b64sc_pkg::MODE_ENCODE;
      group_bits  <= '0;
      group_count <= '0;
      pad_marks   <= '0;
      bad_seen    <= 1'b0;
    end else if (cfg_write) begin
      mode        <= direction_mode;
      group_bits  <= '0;
      group_count <= '0;
      pad_marks   <= '0;
      bad_seen    <= 1'b0;
    end else if (accept) begin
      if (done) begin
        group_bits  <= '0;
        group_count <= '0;
        pad_marks   <= '0;
        bad_seen    <= 1'b0;
      end else begin
        group_bits  <= group_bits_next;
        group_count <= n_items[1:0];
        pad_marks   <= pad_marks_next;
        bad_seen    <= bad_seen_next;
      end
    end
  end

endmodule

/* design/b64sc_back.sv */
module b64sc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  b64sc_pkg::group_t q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_symbol,
  output logic              run_end,
  output logic              bad_symbol
);

  b64sc_pkg::group_t cur;
  logic [3:0] cur_mask;
  logic [1:0] sel;
  logic [3:0] rest;
  logic       emit;

  // Next result to send: lowest pending position
  always_comb begin
    if (cur_mask[0]) begin
      sel = 2'd0;
    end else if (cur_mask[1]) begin
      sel = 2'd1;
    end else if (cur_mask[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
    rest = cur_mask & ~(4'b0001 << sel);
  end

  assign emit  = (|cur_mask) && (!out_valid || out_ready);
  // refill as the last result of the group leaves, so groups run back to back
  assign q_pop = !q_empty && (!(|cur_mask) || (emit && (rest == 4'd0)));

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mask  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_mask <= q_data.keep;
      end else if (emit) begin
        cur_mask <= rest;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (emit) begin
      out_symbol <= cur.sym[sel];
      run_end    <= (rest == 4'd0);
      bad_symbol <= cur.bad;
    end
  end

endmodule

/* design/base64_stream_codec.sv */
// Streaming base64 codec. direction_mode (written with cfg_write, which also
// clears any partly gathered group) selects encode (0) or decode (1). Input
// words are taken at one per cycle while the group queue has room; a word that
// completes a group, or is marked last_in, queues that group's results. The
// output side sends one word per cycle from its output register while results
// wait and the receiver takes them. Throughput is set by the output port when
// encoding (four characters per three bytes) and by the input port when
// decoding, as a group of four characters gives at most three bytes. A group
// passes through the queue and the back's group register before its first
// result is registered and out_valid rises. run_end marks each group's last word;
// bad_symbol flags decoded bytes of a group holding a character outside the alphabet.
module base64_stream_codec #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       direction_mode,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_symbol,
  input  logic       last_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_symbol,
  output logic       run_end,
  output logic       bad_symbol
);

  b64sc_pkg::group_t push_data;
  b64sc_pkg::group_t pop_data;
  logic push;
  logic pop;
  logic full;
  logic empty;

  // Front: gather and classify
  b64sc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .direction_mode (direction_mode),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_symbol      (in_symbol),
    .last_in        (last_in),
    .q_push         (push),
    .q_data         (push_data),
    .q_full         (full)
  );

  // Group queue
  b64sc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  // Back: send results
  b64sc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (empty),
    .q_data     (pop_data),
    .q_pop      (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_symbol (out_symbol),
    .run_end    (run_end),
    .bad_symbol (bad_symbol)
  );

endmodule

/* design/b64sc_checker.sv */
module b64sc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_symbol,
  input logic       run_end,
  input logic       bad_symbol
);

  // Output word stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word withdrawn before it was taken");

  // Stalled output word keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_symbol) && $stable(run_end) && $stable(bad_symbol))
    else $error("stalled output word changed");

  // Reset empties the output register
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // The queue only fills on an accepted input word
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid && in_ready))
    else $error("in_ready dropped without an accepted word");

endmodule

bind base64_stream_codec b64sc_checker u_checker (.*);

/* tb/base64_stream_codec_test.sv */
`timescale 1ns / 1ps

module base64_stream_codec_test;

  localparam int    HALF_PERIOD   = 6;
  localparam int    RESET_CYCLES  = 12;
  localparam int    SETTLE_CYCLES = 16;
  localparam int    HOLD_CYCLES   = 300;
  localparam int    TIMEOUT_NS    = 3_000_000;
  localparam string B64_LETTERS   =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // One output word as the codec should give it
  typedef struct packed {
    logic [7:0] sym;
    logic       fin;
    logic       bad;
  } out_word_t;

  logic       clk            = 1'b0;
  logic       rst            = 1'b1;
  logic       cfg_write      = 1'b0;
  logic       direction_mode = b64sc_pkg::MODE_ENCODE;
  logic       in_valid       = 1'b0;
  logic [7:0] in_symbol      = 8'h00;
  logic       last_in        = 1'b0;
  logic       out_ready      = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_symbol;
  logic       run_end;
  logic       bad_symbol;

  // Shaping of the two sides
  int   idle_pct  = 0;
  int   stall_pct = 0;
  logic hold_on   = 1'b0;
  event hold_go;

  // Own copy of the codec state
  logic        mode_now = b64sc_pkg::MODE_ENCODE;
  logic [23:0] grp_bits = '0;
  int          grp_cnt  = 0;
  logic [3:0]  pad_seen = '0;
  logic        bad_char = 1'b0;

  out_word_t due_words[$];
  int        mismatch_count = 0;
  int        words_in       = 0;
  int        words_out      = 0;

  base64_stream_codec dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .direction_mode (direction_mode),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_symbol      (in_symbol),
    .last_in        (last_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_symbol     (out_symbol),
    .run_end        (run_end),
    .bad_symbol     (bad_symbol)
  );

  always #HALF_PERIOD clk = ~clk;

  // Receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_on) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Long hold-off of the receiver, counted here
  initial begin
    forever begin
      @(hold_go);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_on <= 1'b0;
    end
  end

  // Sextet value of a character, -1 outside the alphabet
  function automatic int b64_value(input logic [7:0] c);
    int k;
    for (k = 0; k < 64; k++) begin
      if (B64_LETTERS[k] == c) return k;
    end
    return -1;
  endfunction

  function automatic logic [7:0] b64_letter(input logic [5:0] v);
    return B64_LETTERS[v];
  endfunction

  function automatic void clear_group();
    grp_bits = '0;
    grp_cnt  = 0;
    pad_seen = '0;
    bad_char = 1'b0;
  endfunction

  // Append one expected word to the tail of the list
  function automatic void add_due(input logic [7:0] sym, input logic fin, input logic bad);
    out_word_t w;
    w.sym = sym;
    w.fin = fin;
    w.bad = bad;
    due_words = {due_words, w};
  endfunction

  // Advance the codec state by one input word and queue what falls out
  task automatic b64_advance(input logic [7:0] s, input logic l);
    out_word_t  w[3];
    logic [7:0] by[3];
    int         v;
    int         n;
    int         kept;
    int         k;
    if (mode_now == b64sc_pkg::MODE_ENCODE) begin
      grp_bits = grp_bits | (24'(s) << (16 - 8 * grp_cnt));
      n = grp_cnt + 1;
      if (n < 3 && !l) begin
        grp_cnt = n;
        return;
      end
      add_due(b64_letter(grp_bits[23:18]), 1'b0, 1'b0);
      add_due(b64_letter(grp_bits[17:12]), 1'b0, 1'b0);
      add_due((n >= 2) ? b64_letter(grp_bits[11:6]) : b64sc_pkg::PAD_CHAR, 1'b0, 1'b0);
      add_due((n >= 3) ? b64_letter(grp_bits[5:0]) : b64sc_pkg::PAD_CHAR, 1'b1, 1'b0);
    end else begin
      if (s == b64sc_pkg::PAD_CHAR) begin
        v = 0;
        pad_seen[grp_cnt] = 1'b1;
      end else begin
        v = b64_value(s);
        if (v < 0) begin
          v = 0;
          bad_char = 1'b1;
        end
      end
      grp_bits = grp_bits | (24'(v) << (18 - 6 * grp_cnt));
      n = grp_cnt + 1;
      if (n < 4 && !l) begin
        grp_cnt = n;
        return;
      end
      // short final group: missing characters count as padding
      for (k = n; k < 4; k++) pad_seen[k] = 1'b1;
      by[0] = grp_bits[23:16];
      by[1] = grp_bits[15:8];
      by[2] = grp_bits[7:0];
      kept = 0;
      for (k = 0; k < 3; k++) begin
        if (by[k] != 8'h00 || !(pad_seen[k] || pad_seen[k+1])) begin
          w[kept] = '{by[k], 1'b0, bad_char};
          kept++;
        end
      end
      if (kept > 0) w[kept-1].fin = 1'b1;
      for (k = 0; k < kept; k++) add_due(w[k].sym, w[k].fin, w[k].bad);
    end
    clear_group();
  endtask

  // Check every word the codec hands over
  always @(posedge clk) begin
    out_word_t w;
    if (!rst && out_valid && out_ready) begin
      words_out++;
      if (due_words.size() == 0) begin
        $error("unexpected word: out_symbol %h run_end %b bad_symbol %b",
               out_symbol, run_end, bad_symbol);
        mismatch_count++;
      end else begin
        w = due_words.pop_front();
        if (out_symbol !== w.sym) begin
          $error("out_symbol: expected %h, got %h", w.sym, out_symbol);
          mismatch_count++;
        end
        if (run_end !== w.fin) begin
          $error("run_end: expected %b, got %b", w.fin, run_end);
          mismatch_count++;
        end
        if (bad_symbol !== w.bad) begin
          $error("bad_symbol: expected %b, got %b", w.bad, bad_symbol);
          mismatch_count++;
        end
      end
    end
  end

  // Offer one word and hold it until taken
  task automatic send_word(input logic [7:0] s, input logic l);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_symbol <= s;
    last_in   <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_in++;
    b64_advance(s, l);
  endtask

  task automatic send_text(input string txt, input logic l);
    int i;
    for (i = 0; i < txt.len(); i++) send_word(txt[i], l && (i == txt.len() - 1));
  endtask

  // Let every pending word come out, then settle for groups that give none
  task automatic drain_results();
    in_valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    drain_results();
    cfg_write      <= 1'b1;
    direction_mode <= m;
    @(posedge clk);
    cfg_write <= 1'b0;
    mode_now = m;
    clear_group();
  endtask

  task automatic test_encode_basics();
    idle_pct  = 0;
    stall_pct = 0;
    set_mode(b64sc_pkg::MODE_ENCODE);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h80, 1'b0);
    // two-byte tail, one pad
    send_word(8'h01, 1'b0);
    send_word(8'h7F, 1'b1);
    // one-byte tail, two pads
    send_word(8'hAA, 1'b1);
    // part group dropped by a mode write
    send_word(8'h55, 1'b0);
    send_word(8'h2C, 1'b0);
    set_mode(b64sc_pkg::MODE_ENCODE);
  endtask

  task automatic test_decode_basics();
    set_mode(b64sc_pkg::MODE_DECODE);
    send_text("+/z9", 1'b0);
    // padding swallows the trailing zero bytes: only the first byte comes out
    send_text("AA==", 1'b0);
    // short final group
    send_text("TW", 1'b1);
    // characters outside the alphabet, zero among them
    send_word(8'h2A, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h41, 1'b0);
  endtask

  task automatic run_encode_mix(input int count);
    int i;
    for (i = 0; i < count; i++) send_word(8'($urandom_range(255)), $urandom_range(7) == 0);
  endtask

  // Mostly well-formed groups, some tails, some noise
  task automatic run_decode_mix(input int count);
    int         sent;
    int         kind;
    int         len;
    int         i;
    logic [7:0] ch;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(99);
      if (kind < 65) begin
        for (i = 0; i < 4; i++) begin
          send_word(b64_letter(6'($urandom_range(63))), (i == 3) && ($urandom_range(5) == 0));
        end
        sent += 4;
      end else if (kind < 77) begin
        len = $urandom_range(2, 3);
        for (i = 0; i < 4; i++) begin
          ch = (i < len) ? b64_letter(6'($urandom_range(63))) : b64sc_pkg::PAD_CHAR;
          send_word(ch, i == 3);
        end
        sent += 4;
      end else if (kind < 87) begin
        len = $urandom_range(1, 3);
        for (i = 0; i < len; i++) send_word(b64_letter(6'($urandom_range(63))), i == len - 1);
        sent += len;
      end else begin
        ch = ($urandom_range(3) == 0) ? b64sc_pkg::PAD_CHAR : 8'($urandom_range(255));
        send_word(ch, $urandom_range(7) == 0);
        sent++;
      end
    end
  endtask

  task automatic test_encode_flow();
    set_mode(b64sc_pkg::MODE_ENCODE);
    idle_pct  = 0;
    stall_pct = 0;
    run_encode_mix(40);
  endtask

  task automatic test_encode_sender_idle();
    set_mode(b64sc_pkg::MODE_ENCODE);
    idle_pct  = 71;
    stall_pct = 0;
    run_encode_mix(35);
  endtask

  task automatic test_decode_receiver_stall();
    set_mode(b64sc_pkg::MODE_DECODE);
    idle_pct  = 0;
    stall_pct = 71;
    run_decode_mix(50);
  endtask

  task automatic test_decode_both_idle();
    set_mode(b64sc_pkg::MODE_DECODE);
    idle_pct  = 6;
    stall_pct = 6;
    run_decode_mix(50);
  endtask

  // Receiver held off while the sender keeps offering bytes
  task automatic test_back_pressure();
    set_mode(b64sc_pkg::MODE_ENCODE);
    idle_pct  = 0;
    stall_pct = 0;
    -> hold_go;
    run_encode_mix(30);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_encode_basics();
    test_decode_basics();
    test_encode_flow();
    test_encode_sender_idle();
    test_decode_receiver_stall();
    test_decode_both_idle();
    test_back_pressure();
    drain_results();
    $display("Ran %0d input words through encode and decode, %0d output words checked,",
             words_in, words_out);
    $display("with idle sender, stalled receiver and a long receiver hold-off.");
    if (mismatch_count == 0 && due_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #TIMEOUT_NS;
    $display("Test completed with failures");
    $finish;
  end

endmodule
